// ===== rtl/mapd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapd_pkg: shared types and constants of the maze path enumerator
// Stack entry layout, configuration register indexes, direction codes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mapd_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_WALL_MAP  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_ROW = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_COL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_ROW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_COL  = 3'd4;

  // register reset values
  localparam logic [2:0] GOAL_ROW_RST = 3'd7;
  localparam logic [2:0] GOAL_COL_RST = 3'd7;

  // direction codes, tried in this order; DIR_NONE means all tried
  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // one stack entry: next direction to try and cell (row*8+col)
  typedef struct packed {
    logic [2:0] dir;
    logic [2:0] row;
    logic [2:0] col;
  } mapd_entry_t;

  // controller to datapath
  typedef struct packed {
    logic restart;     // clear the path and push the start cell
    logic rd_top;      // read the top of stack
    logic eval_step;   // record the chosen direction or pop the top
    logic push;        // push the chosen neighbor
    logic set_done;    // mark the search exhausted
    logic emit_first;  // point the emit index at the bottom entry
    logic emit_rd;     // read the entry under the emit index
    logic load_cell;   // load a path cell into the output register
    logic load_exh;    // load the exhausted item into the output register
  } mapd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;        // no search active
    logic empty;       // stack holds no cell
    logic is_goal;     // top entry is the goal cell
    logic move_found;  // a neighbor can be entered from the top entry
    logic emit_last;   // emit index is on the top entry
    logic out_free;    // output register can take an item this cycle
  } mapd_status_t;

endpackage

// ===== rtl/mapd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapd_datapath: stack, visited map, neighbor check and output register
// Holds the configuration registers and the path stack memory, works out the
// next direction from the top entry and drives the result stream.
// ----------------------------------------------------------------------------
module mapd_datapath #(
  parameter int unsigned GRID_SIZE   = 8,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mapd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mapd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  mapd_pkg::mapd_cmd_t              cmd_i,
  output mapd_pkg::mapd_status_t           status_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // cell_row, cell_col, zeros
  output logic                             m_axis_tlast,  // last_cell
  output logic                             m_axis_tuser   // exhausted
);
  import mapd_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [3:0]    GRID_W = 4'(GRID_SIZE);
  localparam logic [2:0]    GRID_MAX = 3'(GRID_SIZE - 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  // configuration registers
  logic [63:0] wall_q;
  logic [2:0]  start_row_q, start_col_q, goal_row_q, goal_col_q;

  // search state
  logic [DW-1:0] depth_q, depth_d;
  logic [63:0]   visited_q, visited_d;
  logic          done_q, done_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [5:0]    nxt_q, nxt_d;

  // stack memory port signals
  mapd_entry_t   stack_mem [STACK_DEPTH];
  mapd_entry_t   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  mapd_entry_t   mem_wd;

  // output register
  logic       out_valid_q;
  logic [2:0] out_row_q, out_col_q;
  logic       out_last_q, out_exh_q;

  logic [AW-1:0] top_addr;
  logic [5:0]    top_cell;
  logic          start_in;
  logic          full;
  logic [3:0]    dir_ok;
  logic [5:0]    dir_cell [4];
  logic          found;
  logic [1:0]    sel;
  logic          emit_last;
  logic          out_free;

  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q      <= '0;
      start_row_q <= '0;
      start_col_q <= '0;
      goal_row_q  <= GOAL_ROW_RST;
      goal_col_q  <= GOAL_COL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WALL_MAP:  wall_q      <= cfg_data_i;
        CFG_START_ROW: start_row_q <= cfg_data_i[2:0];
        CFG_START_COL: start_col_q <= cfg_data_i[2:0];
        CFG_GOAL_ROW:  goal_row_q  <= cfg_data_i[2:0];
        CFG_GOAL_COL:  goal_col_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign top_addr = AW'(depth_q - DW'(1));
  assign top_cell = {rd_q.row, rd_q.col};
  assign start_in = ({1'b0, start_row_q} < GRID_W) && ({1'b0, start_col_q} < GRID_W);
  assign full     = (depth_q >= DEPTH_FULL);

  // neighbor candidates of the top entry
  always_comb begin
    dir_cell[DIR_UP[1:0]]    = {rd_q.row - 3'd1, rd_q.col};
    dir_cell[DIR_RIGHT[1:0]] = {rd_q.row, rd_q.col + 3'd1};
    dir_cell[DIR_DOWN[1:0]]  = {rd_q.row + 3'd1, rd_q.col};
    dir_cell[DIR_LEFT[1:0]]  = {rd_q.row, rd_q.col - 3'd1};
    dir_ok[DIR_UP[1:0]]      = (rd_q.row != 3'd0);
    dir_ok[DIR_RIGHT[1:0]]   = (rd_q.col < GRID_MAX);
    dir_ok[DIR_DOWN[1:0]]    = (rd_q.row < GRID_MAX);
    dir_ok[DIR_LEFT[1:0]]    = (rd_q.col != 3'd0);
    for (int k = 0; k < 4; k++) begin
      dir_ok[k] = dir_ok[k] && !wall_q[dir_cell[k]] && !visited_q[dir_cell[k]] &&
                  !full && (3'(k) >= rd_q.dir);
    end
  end

  // first open direction wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = 3; k >= 0; k--) begin
      if (dir_ok[k]) begin
        found = 1'b1;
        sel   = 2'(k);
      end
    end
  end

  assign emit_last = ((DW'(idx_q) + DW'(1)) == depth_q);
  assign out_free  = !out_valid_q || m_axis_tready;

  // stack write and read port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '{dir: DIR_UP, row: start_row_q, col: start_col_q};
    if (cmd_i.restart && start_in) begin
      mem_we = 1'b1;
    end else if (cmd_i.eval_step && found) begin
      mem_we = 1'b1;
      mem_wa = top_addr;
      mem_wd = '{dir: {1'b0, sel} + 3'd1, row: rd_q.row, col: rd_q.col};
    end else if (cmd_i.push) begin
      mem_we = 1'b1;
      mem_wa = AW'(depth_q);
      mem_wd = '{dir: DIR_UP, row: nxt_q[5:3], col: nxt_q[2:0]};
    end
    mem_re = cmd_i.rd_top || cmd_i.emit_rd;
    mem_ra = cmd_i.emit_rd ? idx_q : top_addr;
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= stack_mem[mem_ra];
    end
  end

  // depth, visited map, done flag, emit index
  always_comb begin
    depth_d   = depth_q;
    visited_d = visited_q;
    done_d    = done_q;
    idx_d     = idx_q;
    nxt_d     = nxt_q;
    if (cmd_i.restart) begin
      depth_d   = '0;
      visited_d = '0;
      done_d    = 1'b1;
      if (start_in) begin
        depth_d                               = DW'(1);
        visited_d[{start_row_q, start_col_q}] = 1'b1;
        done_d                                = 1'b0;
      end
    end else if (cmd_i.eval_step) begin
      if (found) begin
        nxt_d = dir_cell[sel];
      end else begin
        depth_d             = depth_q - DW'(1);
        visited_d[top_cell] = 1'b0;
      end
    end else if (cmd_i.push) begin
      depth_d          = depth_q + DW'(1);
      visited_d[nxt_q] = 1'b1;
    end else if (cmd_i.load_cell) begin
      if (emit_last) begin
        depth_d             = depth_q - DW'(1);
        visited_d[top_cell] = 1'b0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
    if (cmd_i.emit_first) begin
      idx_d = '0;
    end
    if (cmd_i.set_done) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      visited_q <= '0;
      done_q    <= 1'b1;
    end else begin
      depth_q   <= depth_d;
      visited_q <= visited_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    nxt_q <= nxt_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_cell || cmd_i.load_exh) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cell) begin
      out_row_q  <= rd_q.row;
      out_col_q  <= rd_q.col;
      out_last_q <= emit_last;
      out_exh_q  <= 1'b0;
    end else if (cmd_i.load_exh) begin
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_last_q <= 1'b0;
      out_exh_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_exh_q;

  // status to the controller
  assign status_o.done       = done_q;
  assign status_o.empty      = (depth_q == '0);
  assign status_o.is_goal    = (rd_q.row == goal_row_q) && (rd_q.col == goal_col_q);
  assign status_o.move_found = found;
  assign status_o.emit_last  = emit_last;
  assign status_o.out_free   = out_free;

endmodule

// ===== rtl/mapd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapd_ctrl: search sequencer
// Accepts a request, steps the depth-first search one stack entry at a time
// and sequences the emission of a found path or of the exhausted item.
// ----------------------------------------------------------------------------
module mapd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic                   restart_i,
  input  mapd_pkg::mapd_status_t status_i,
  output mapd_pkg::mapd_cmd_t    cmd_o
);
  import mapd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CHECK    = 7'b0000010,
    ST_EVAL     = 7'b0000100,
    ST_PUSH     = 7'b0001000,
    ST_EMIT_RD  = 7'b0010000,
    ST_EMIT_OUT = 7'b0100000,
    ST_EXH      = 7'b1000000
  } mapd_state_e;

  mapd_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.restart = restart_i;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.done || status_i.empty) begin
          cmd_o.set_done = 1'b1;
          state_d        = ST_EXH;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.is_goal) begin
          cmd_o.emit_first = 1'b1;
          state_d          = ST_EMIT_RD;
        end else begin
          cmd_o.eval_step = 1'b1;
          state_d         = status_i.move_found ? ST_PUSH : ST_CHECK;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_cell = 1'b1;
          state_d         = status_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EXH: begin
        if (status_i.out_free) begin
          cmd_o.load_exh = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/maze_all_paths_dfs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_all_paths_dfs: enumerator of all simple paths in a grid maze
// Depth-first backtracking search from start to goal cell; each request
// yields the next path, one cell per item, or one exhausted item.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken, the search runs until the next
// path reaches the goal, and the path streams out start first, goal last with
// tlast, or a single item with tuser set once no path is left. The search
// walks a stack memory with one read port, so each forward move takes the
// steps read top, choose direction and push, and each backtrack only read
// top and choose direction; each path cell is read from the stack and then
// loaded into the output register, which waits while the output stalls.
// The total per request depends on the maze and the number of search steps.
// The last item of a request may still wait in the output register while
// the next request is taken.
module maze_all_paths_dfs #(
  parameter int unsigned GRID_SIZE   = 8,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mapd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mapd_pkg::CfgDataW-1:0] cfg_data_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // restart, zeros
  // path cell stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // cell_row, cell_col, zeros
  output logic                          m_axis_tlast,   // last_cell
  output logic                          m_axis_tuser    // exhausted
);
  import mapd_pkg::*;

  mapd_cmd_t    cmd;
  mapd_status_t status;

  // search sequencer
  mapd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .restart_i     (s_axis_tdata[0]),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // stack, maps and output register
  mapd_datapath #(
    .GRID_SIZE   (GRID_SIZE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/mapd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapd_checker: port-level checks of the maze path enumerator
// Watches the top-level ports and flags stream and result-format slips.
// ----------------------------------------------------------------------------
module mapd_checker #(
  parameter int unsigned GRID_SIZE = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  localparam logic [3:0] GRID_W = 4'(GRID_SIZE);

  // a stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("result item changed while stalled");

  // an exhausted item carries no cell and no last mark
  a_exh_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))
    else $error("exhausted item carries cell data");

  // path cells lie inside the grid
  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (({1'b0, m_axis_tdata[2:0]} < GRID_W) && ({1'b0, m_axis_tdata[5:3]} < GRID_W) &&
       (m_axis_tdata[7:6] == 2'b00)))
    else $error("path cell outside the grid");

  // one request at a time: no new request right after one is taken
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while the previous one is in work");

endmodule

bind maze_all_paths_dfs mapd_checker #(.GRID_SIZE(GRID_SIZE)) u_mapd_checker (.*);
